>>> hw/rtl/lct_pkg.sv
`default_nettype none
package lct_pkg;

  localparam int SAMPLE_W   = 25;
  localparam int GAIN_W     = 24;
  localparam int NORM_W     = 32;
  localparam int GAMMA_W    = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CHAN_W     = 8;
  localparam int LAYERS_MAX = 3;

  localparam int Y_W        = 17;
  localparam int X_MAX      = 16777215;
  localparam int Q16_ONE    = 65536;

  localparam int M_W        = 31;
  localparam int FRAC_W     = 16;
  localparam int LOG_LAT    = FRAC_W + 2;

  localparam int SQ_IN_W    = 61;
  localparam int SQ_RES_W   = 64;
  localparam int ROOT_W     = 31;
  localparam int SQRT_ITERS = 16;
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_PER   = 2;
  localparam int SQRT_LAT   = SQRT_STEPS / SQRT_PER;

  localparam int T_W        = 25;

  localparam int LANE_LAT   = 4 + LOG_LAT + 1 + LOG_LAT + 1 + SQRT_ITERS * SQRT_LAT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYER0_GAIN    = 3'd0,
    REG_LAYER1_GAIN    = 3'd1,
    REG_LAYER2_GAIN    = 3'd2,
    REG_EXPOSURE_GAIN  = 3'd3,
    REG_CURVE_STRENGTH = 3'd4,
    REG_CURVE_NORM     = 3'd5,
    REG_INVERSE_GAMMA  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [LAYERS_MAX-1:0][GAIN_W-1:0] layer_gain;
    logic [GAIN_W-1:0]                 exposure_gain;
    logic [GAIN_W-1:0]                 curve_strength;
    logic [NORM_W-1:0]                 curve_norm;
    logic [GAMMA_W-1:0]                inverse_gamma;
  } cfg_t;

  typedef struct packed {
    logic [SQ_IN_W-1:0]  rem;
    logic [SQ_RES_W-1:0] res;
  } sq_state_t;

  // one digit of the bit-pair square root
  function automatic sq_state_t sqrt_step(sq_state_t s, logic [SQ_RES_W-1:0] bitv);
    sq_state_t o;
    logic [SQ_RES_W-1:0] trial;
    trial = s.res + bitv;
    o = s;
    if (SQ_RES_W'(s.rem) >= trial) begin
      o.rem = s.rem - trial[SQ_IN_W-1:0];
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lct_log2q.sv
`default_nettype none
module lct_log2q import lct_pkg::*; #(
  parameter int IN_W = 49,
  parameter int SB_W = 24
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [IN_W-1:0]          v,
  input  wire logic [SB_W-1:0]          sb_in,
  output logic      [$clog2(IN_W)-1:0]  e,
  output logic      [FRAC_W-1:0]        f,
  output logic      [SB_W-1:0]          sb_out
);
  localparam int E_W  = $clog2(IN_W);
  localparam int WW   = IN_W + M_W;

  logic [E_W-1:0]  e_find;
  logic [IN_W-1:0] v1;
  logic [E_W-1:0]  e1;
  logic [SB_W-1:0] sb1;
  logic [WW-1:0]   ext;

  logic [M_W-1:0]    m_q  [FRAC_W+1];
  logic [FRAC_W-1:0] f_q  [FRAC_W+1];
  logic [E_W-1:0]    e_q  [FRAC_W+1];
  logic [SB_W-1:0]   sb_q [FRAC_W+1];

  // top set bit
  always_comb begin
    e_find = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (v[i]) e_find = E_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1  <= v;
      e1  <= e_find;
      sb1 <= sb_in;
    end
  end

  // scale to q1.30
  always_comb ext = (WW'(v1) << 30) >> e1;

  always_ff @(posedge clk) begin
    if (en) begin
      m_q[0]  <= ext[M_W-1:0];
      f_q[0]  <= '0;
      e_q[0]  <= e1;
      sb_q[0] <= sb1;
    end
  end

  for (genvar g = 0; g < FRAC_W; g++) begin : g_sq
    logic [2*M_W-1:0] sq;
    logic [M_W:0]     mm;
    logic [M_W-1:0]   m_nx;
    logic             fb;
    always_comb begin
      sq = m_q[g] * m_q[g];
      mm = sq[2*M_W-1:M_W-1];
      fb = mm[M_W];
      m_nx = fb ? mm[M_W:1] : mm[M_W-1:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        m_q[g+1]  <= m_nx;
        f_q[g+1]  <= {f_q[g][FRAC_W-2:0], fb};
        e_q[g+1]  <= e_q[g];
        sb_q[g+1] <= sb_q[g];
      end
    end
  end

  assign e      = e_q[FRAC_W];
  assign f      = f_q[FRAC_W];
  assign sb_out = sb_q[FRAC_W];

endmodule
`default_nettype wire

>>> hw/rtl/lct_isqrt.sv
`default_nettype none
module lct_isqrt import lct_pkg::*; #(
  parameter int SB_W = 42
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [SQ_IN_W-1:0] v,
  input  wire logic [SB_W-1:0]    sb_in,
  output logic      [ROOT_W-1:0]  root,
  output logic      [SB_W-1:0]    sb_out
);
  sq_state_t       st_q [SQRT_LAT+1];
  logic [SB_W-1:0] sb_q [SQRT_LAT+1];

  always_comb begin
    st_q[0].rem = v;
    st_q[0].res = '0;
    sb_q[0]     = sb_in;
  end

  for (genvar g = 0; g < SQRT_LAT; g++) begin : g_st
    sq_state_t s_mid;
    sq_state_t s_nx;
    always_comb begin
      s_mid = sqrt_step(st_q[g], SQ_RES_W'(1) << (62 - 2 * (SQRT_PER * g)));
      s_nx  = sqrt_step(s_mid,   SQ_RES_W'(1) << (60 - 2 * (SQRT_PER * g)));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_q[g+1] <= s_nx;
        sb_q[g+1] <= sb_q[g];
      end
    end
  end

  assign root   = st_q[SQRT_LAT].res[ROOT_W-1:0];
  assign sb_out = sb_q[SQRT_LAT];

endmodule
`default_nettype wire

>>> hw/rtl/lct_lane.sv
`default_nettype none
module lct_lane import lct_pkg::*; #(
  parameter int NUM_LAYERS  = 3,
  parameter int OUTPUT_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire cfg_t                                cfg,
  input  wire logic [LAYERS_MAX-1:0][SAMPLE_W-1:0] sample,
  output logic      [CHAN_W-1:0]                   result
);
  localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int V_W    = 49;
  localparam int EA_W   = $clog2(V_W);
  localparam int EB_W   = $clog2(Y_W);
  localparam int L_W    = 21;
  localparam int SB_W   = T_W + Y_W;
  localparam int OW     = Y_W + OUTPUT_BITS + 1;
  localparam int MAXV   = (1 << OUTPUT_BITS) - 1;

  logic signed [PROD_W-1:0] prod [LAYERS_MAX];
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-17:0]        sum_hi;
  logic [GAIN_W-1:0]        s2, s_nx;
  logic [2*GAIN_W-1:0]      xp;
  logic [GAIN_W-1:0]        x3, x4;
  logic [V_W-1:0]           v4;

  logic [EA_W-1:0]          e_a;
  logic [FRAC_W-1:0]        f_a;
  logic [GAIN_W-1:0]        x_a;
  logic [L_W-1:0]           lv;
  logic [L_W+NORM_W-1:0]    yp;
  logic [Y_W-1:0]           y5, y_nx;

  logic [EB_W-1:0]          e_b;
  logic [FRAC_W-1:0]        f_b;
  logic [Y_W-1:0]           y_b;
  logic [L_W-1:0]           n_v;
  logic [L_W+GAMMA_W-1:0]   tp;
  logic [T_W-1:0]           t6;
  logic [Y_W-1:0]           y6;

  logic [ROOT_W-1:0]        a_q  [SQRT_ITERS+1];
  logic [SB_W-1:0]          sb_q [SQRT_ITERS+1];

  logic [T_W-1:0]           t_f;
  logic [Y_W-1:0]           y_f, y_g, y_sel;
  logic [9:0]               sh;
  logic [ROOT_W-1:0]        a_sh;
  logic [OW-1:0]            rnd;

  // weighted products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LAYERS_MAX; k++) begin
        if (k < NUM_LAYERS) begin
          prod[k] <= $signed(sample[k]) * $signed({1'b0, cfg.layer_gain[k]});
        end else begin
          prod[k] <= '0;
        end
      end
    end
  end

  // sum, clamp negatives, saturate
  always_comb begin
    sum    = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
    sum_hi = sum[SUM_W-1:16];
    if (sum[SUM_W-1] || sum == '0) begin
      s_nx = '0;
    end else if (sum_hi > (SUM_W-16)'(X_MAX)) begin
      s_nx = GAIN_W'(X_MAX);
    end else begin
      s_nx = sum_hi[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) s2 <= s_nx;
  end

  // exposure
  always_comb xp = s2 * cfg.exposure_gain;

  always_ff @(posedge clk) begin
    if (en) x3 <= (xp[2*GAIN_W-1:16] > 32'(X_MAX)) ? GAIN_W'(X_MAX) : xp[GAIN_W+15:16];
  end

  // argument of the curve log
  always_ff @(posedge clk) begin
    if (en) begin
      v4 <= V_W'(cfg.curve_strength) * V_W'(x3) + (V_W'(1) << 32);
      x4 <= x3;
    end
  end

  lct_log2q #(.IN_W(V_W), .SB_W(GAIN_W)) u_log_curve (
    .clk    (clk),
    .en     (en),
    .v      (v4),
    .sb_in  (x4),
    .e      (e_a),
    .f      (f_a),
    .sb_out (x_a)
  );

  // scale by norm and clamp to one; with zero curve strength, the exposed value clamped to one
  always_comb begin
    lv = L_W'({e_a, f_a} - (EA_W + FRAC_W)'(32 << 16));
    yp = lv * cfg.curve_norm;
    if (cfg.curve_strength != '0) begin
      y_nx = (yp[L_W+NORM_W-1:16] > (L_W+NORM_W-16)'(Q16_ONE)) ?
             Y_W'(Q16_ONE) : yp[Y_W+15:16];
    end else begin
      y_nx = (x_a > GAIN_W'(Q16_ONE)) ? Y_W'(Q16_ONE) : x_a[Y_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) y5 <= y_nx;
  end

  lct_log2q #(.IN_W(Y_W), .SB_W(Y_W)) u_log_gamma (
    .clk    (clk),
    .en     (en),
    .v      (y5),
    .sb_in  (y5),
    .e      (e_b),
    .f      (f_b),
    .sb_out (y_b)
  );

  // exponent of the power, negated log times p
  always_comb begin
    n_v = (L_W'(1) << 20) - L_W'({e_b, f_b});
    tp  = n_v * cfg.inverse_gamma;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6 <= tp[L_W+GAMMA_W-1:16];
      y6 <= y_b;
    end
  end

  assign a_q[0]  = ROOT_W'(1) << 30;
  assign sb_q[0] = {t6, y6};

  // exp2 of the fraction, one square root per fraction bit
  for (genvar g = 0; g < SQRT_ITERS; g++) begin : g_exp
    logic [ROOT_W-1:0] a_half;
    always_comb a_half = sb_q[g][Y_W+g] ? (a_q[g] >> 1) : a_q[g];
    lct_isqrt #(.SB_W(SB_W)) u_sqrt (
      .clk    (clk),
      .en     (en),
      .v      ({a_half, 30'b0}),
      .sb_in  (sb_q[g]),
      .root   (a_q[g+1]),
      .sb_out (sb_q[g+1])
    );
  end

  // integer part of the exponent, bypasses, rounding
  always_comb begin
    t_f  = sb_q[SQRT_ITERS][SB_W-1:Y_W];
    y_f  = sb_q[SQRT_ITERS][Y_W-1:0];
    sh   = 10'(t_f[T_W-1:16]) + 10'd14;
    a_sh = (sh >= 10'd64) ? '0 : (a_q[SQRT_ITERS] >> sh[5:0]);
    y_g  = (a_sh > ROOT_W'(Q16_ONE)) ? Y_W'(Q16_ONE) : a_sh[Y_W-1:0];
    if (cfg.inverse_gamma == GAMMA_W'(Q16_ONE)) begin
      y_sel = y_f;
    end else if (cfg.inverse_gamma == '0) begin
      y_sel = Y_W'(Q16_ONE);
    end else if (y_f == '0) begin
      y_sel = '0;
    end else begin
      y_sel = y_g;
    end
    rnd = OW'(y_sel) * OW'(MAXV) + OW'(32768);
  end

  always_ff @(posedge clk) begin
    if (en) result <= rnd[CHAN_W+15:16];
  end

endmodule
`default_nettype wire

>>> hw/rtl/layer_composite_log_tonemap.sv
// throughput: one item per cycle unless a result waits on m_tready, set by the
//   fully pipelined lanes; the slowest piece is the exp2 chain of 16 square
//   roots, each 16 stages of two digits
// reset (rst, synchronous): clears all valid bits and loads every config register
//   with its default; payload registers are not reset
`default_nettype none
module layer_composite_log_tonemap import lct_pkg::*; #(
  parameter int NUM_LAYERS  = 3,
  parameter int OUTPUT_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // config write port
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input pixels
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // l0_red, l0_green, l0_blue, l1_red, l1_green, l1_blue, l2_red, l2_green,
  // l2_blue (25 bits each), 7 zero pad bits on top
  input  wire logic [231:0]          s_tdata,
  // output pixels
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // out_red, out_green, out_blue (8 bits each)
  output logic [23:0]                m_tdata
);
  localparam int NCH = 3;

  cfg_t                                cfg;
  logic [LANE_LAT-1:0]                 vld;
  logic                                en;
  logic                                out_load;
  logic [NCH-1:0][CHAN_W-1:0]          lane_res;

  // config registers, defaults as documented
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.layer_gain[0]  <= GAIN_W'(65536);
      cfg.layer_gain[1]  <= '0;
      cfg.layer_gain[2]  <= '0;
      cfg.exposure_gain  <= GAIN_W'(65536);
      cfg.curve_strength <= GAIN_W'(6488064);
      cfg.curve_norm     <= NORM_W'(9864);
      cfg.inverse_gamma  <= GAMMA_W'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LAYER0_GAIN:    cfg.layer_gain[0]  <= cfg_data[GAIN_W-1:0];
        REG_LAYER1_GAIN:    cfg.layer_gain[1]  <= cfg_data[GAIN_W-1:0];
        REG_LAYER2_GAIN:    cfg.layer_gain[2]  <= cfg_data[GAIN_W-1:0];
        REG_EXPOSURE_GAIN:  cfg.exposure_gain  <= cfg_data[GAIN_W-1:0];
        REG_CURVE_STRENGTH: cfg.curve_strength <= cfg_data[GAIN_W-1:0];
        REG_CURVE_NORM:     cfg.curve_norm     <= cfg_data[NORM_W-1:0];
        REG_INVERSE_GAMMA:  cfg.inverse_gamma  <= cfg_data[GAMMA_W-1:0];
        default: ;  // index past the list, write dropped
      endcase
    end
  end

  // the pipeline moves unless its last stage holds an item the output register
  // cannot take, so items flow while a result waits until the last stage fills
  assign out_load = !m_tvalid || m_tready;
  assign en       = !vld[LANE_LAT-1] || out_load;
  assign s_tready = en;

  // item valid marks, one per lane stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_LAT-2:0], s_tvalid};
    end
  end

  // one lane per color channel, each sees that channel of all layers
  for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
    logic [LAYERS_MAX-1:0][SAMPLE_W-1:0] smp;
    for (genvar k = 0; k < LAYERS_MAX; k++) begin : g_smp
      assign smp[k] = s_tdata[(k * NCH + ch) * SAMPLE_W +: SAMPLE_W];
    end
    lct_lane #(.NUM_LAYERS(NUM_LAYERS), .OUTPUT_BITS(OUTPUT_BITS)) u_lane (
      .clk    (clk),
      .en     (en),
      .cfg    (cfg),
      .sample (smp),
      .result (lane_res[ch])
    );
  end

  // merge the three channels into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && vld[LANE_LAT-1]) m_tdata <= lane_res;
  end

endmodule
`default_nettype wire

>>> hw/rtl/lct_checker.sv
`default_nettype none
module lct_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [23:0]           m_tdata
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input only backs up behind a stalled result
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled with output free");

  // a held result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // no result is valid when reset is first seen released
  a_no_early: assert property (@(posedge clk)
    $fell(rst) |-> !m_tvalid)
    else $error("result ahead of pipeline fill");

endmodule

bind layer_composite_log_tonemap lct_checker u_lct_checker (.*);
`default_nettype wire
